>>> hdl/rsa_mexp_pkg.sv
// Shared widths, register indexes and multiplier handshake types for the modular exponentiation core
`timescale 1ns / 1ps

package rsa_mexp_pkg;

  // Arithmetic widths
  localparam int MOD_WIDTH = 16;
  localparam int EXP_WIDTH = 16;
  localparam int MM_CNT_W  = $clog2(MOD_WIDTH);
  localparam int EXP_CNT_W = $clog2(EXP_WIDTH);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ENC_EXP = 2'd0,
    REG_ENC_MOD = 2'd1,
    REG_DEC_EXP = 2'd2,
    REG_DEC_MOD = 2'd3
  } reg_idx_t;

  // Request to the modular multiplier: product a*b mod n, a already below n
  typedef struct packed {
    logic                 go;
    logic [MOD_WIDTH-1:0] a;
    logic [MOD_WIDTH-1:0] b;
    logic [MOD_WIDTH-1:0] n;
  } mm_req_t;

  // Response from the modular multiplier
  typedef struct packed {
    logic                 done;
    logic [MOD_WIDTH-1:0] p;
  } mm_rsp_t;

endpackage

>>> hdl/rsa_mexp_mulmod.sv
// Bit-serial modular multiplier using add-and-double, one multiplier bit per cycle
`timescale 1ns / 1ps

module rsa_mexp_mulmod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsa_mexp_pkg::mm_req_t req,
  output rsa_mexp_pkg::mm_rsp_t rsp
);
  import rsa_mexp_pkg::*;

  typedef enum logic {
    MM_IDLE,
    MM_RUN
  } mm_state_t;

  mm_state_t            state_r;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] b_r;
  logic [MOD_WIDTH-1:0] n_r;
  logic [MOD_WIDTH-1:0] acc_r;
  logic [MM_CNT_W-1:0]  cnt_r;
  logic                 done_r;

  // (x + y) mod n for x, y below n; a modulus of zero wraps at the word width
  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                    input logic [MOD_WIDTH-1:0] y,
                                                    input logic [MOD_WIDTH-1:0] n);
    logic [MOD_WIDTH:0] s;
    logic [MOD_WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, n};
    if (n == '0) begin
      add_mod = s[MOD_WIDTH-1:0];
    end else if (s >= {1'b0, n}) begin
      add_mod = d[MOD_WIDTH-1:0];
    end else begin
      add_mod = s[MOD_WIDTH-1:0];
    end
  endfunction

  // Sequencer and datapath: scan b from its low bit, accumulate and double a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MM_IDLE: begin
          if (req.go) begin
            a_r     <= req.a;
            b_r     <= req.b;
            n_r     <= req.n;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= MM_RUN;
          end
        end
        MM_RUN: begin
          if (b_r[0]) begin
            acc_r <= add_mod(acc_r, a_r, n_r);
          end
          a_r   <= add_mod(a_r, a_r, n_r);
          b_r   <= b_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MM_CNT_W'(MOD_WIDTH - 1)) begin
            done_r  <= 1'b1;
            state_r <= MM_IDLE;
          end
        end
        default: state_r <= MM_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

>>> hdl/rsa_modular_exponentiation_core.sv
// Top level: register file, square-and-multiply sequencer and result strobe
// The bit-serial multiplier serves one reducing multiply and then, for every exponent bit, a
// multiply where the bit is set followed by a square; all exponent bits are always scanned.
// A zero exponent gives the result strobe in the cycle after the start beat, with no multiply.
// Throughput: one item at a time, busy high until the result strobe; results cannot be stalled.
// Reset: synchronous active-low rst_n; exponents reset to 1, moduli to 2, sequencer to idle.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [rsa_mexp_pkg::MOD_WIDTH-1:0]    in_value,
  // result channel
  output logic                                  out_valid,
  output logic [rsa_mexp_pkg::MOD_WIDTH-1:0]    out_result_value,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rsa_mexp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rsa_mexp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rsa_mexp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import rsa_mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_MUL,
    S_SQR
  } state_t;

  // configuration registers
  logic [EXP_WIDTH-1:0] enc_exp_r;
  logic [MOD_WIDTH-1:0] enc_mod_r;
  logic [EXP_WIDTH-1:0] dec_exp_r;
  logic [MOD_WIDTH-1:0] dec_mod_r;

  // sequencer
  state_t               state_r;
  logic [EXP_WIDTH-1:0] exp_r;
  logic [MOD_WIDTH-1:0] n_r;
  logic [MOD_WIDTH-1:0] acc_r;
  logic [MOD_WIDTH-1:0] base_r;
  logic [EXP_CNT_W-1:0] bit_r;
  logic                 out_valid_r;
  logic [MOD_WIDTH-1:0] out_value_r;
  mm_req_t              mm_req_r;
  mm_rsp_t              mm_rsp;

  logic                 accept;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic [EXP_WIDTH-1:0] sel_exp;
  logic [MOD_WIDTH-1:0] sel_mod;
  logic [MOD_WIDTH-1:0] one_mod;

  // configuration access
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_exp_r <= EXP_WIDTH'(1);
      enc_mod_r <= MOD_WIDTH'(2);
      dec_exp_r <= EXP_WIDTH'(1);
      dec_mod_r <= MOD_WIDTH'(2);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENC_EXP: enc_exp_r <= pwdata[EXP_WIDTH-1:0];
        REG_ENC_MOD: enc_mod_r <= pwdata[MOD_WIDTH-1:0];
        REG_DEC_EXP: dec_exp_r <= pwdata[EXP_WIDTH-1:0];
        REG_DEC_MOD: dec_mod_r <= pwdata[MOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENC_EXP: prdata = CFG_DATA_W'(enc_exp_r);
      REG_ENC_MOD: prdata = CFG_DATA_W'(enc_mod_r);
      REG_DEC_EXP: prdata = CFG_DATA_W'(dec_exp_r);
      REG_DEC_MOD: prdata = CFG_DATA_W'(dec_mod_r);
      default:     prdata = '0;
    endcase
  end

  // key selection for the incoming beat; 1 mod n is 0 only for a modulus of one
  assign busy    = (state_r != S_IDLE);
  assign accept  = start & ~busy;
  assign sel_exp = in_kind ? dec_exp_r : enc_exp_r;
  assign sel_mod = in_kind ? dec_mod_r : enc_mod_r;
  assign one_mod = (sel_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  // square-and-multiply sequencer, low exponent bit first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mm_req_r.go <= 1'b0;
      bit_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      mm_req_r.go <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (sel_exp == '0) begin
              out_valid_r <= 1'b1;
              out_value_r <= MOD_WIDTH'(1);
            end else begin
              // reduce the value: (1 mod n) * value mod n
              exp_r       <= sel_exp;
              n_r         <= sel_mod;
              acc_r       <= one_mod;
              bit_r       <= '0;
              mm_req_r.go <= 1'b1;
              mm_req_r.a  <= one_mod;
              mm_req_r.b  <= in_value;
              mm_req_r.n  <= sel_mod;
              state_r     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mm_rsp.done) begin
            base_r  <= mm_rsp.p;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          mm_req_r.go <= 1'b1;
          mm_req_r.n  <= n_r;
          if (exp_r[bit_r]) begin
            mm_req_r.a <= acc_r;
            mm_req_r.b <= base_r;
            state_r    <= S_MUL;
          end else begin
            mm_req_r.a <= base_r;
            mm_req_r.b <= base_r;
            state_r    <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_rsp.done) begin
            acc_r       <= mm_rsp.p;
            mm_req_r.go <= 1'b1;
            mm_req_r.a  <= base_r;
            mm_req_r.b  <= base_r;
            mm_req_r.n  <= n_r;
            state_r     <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_rsp.done) begin
            base_r <= mm_rsp.p;
            if (bit_r == EXP_CNT_W'(EXP_WIDTH - 1)) begin
              out_valid_r <= 1'b1;
              out_value_r <= acc_r;
              state_r     <= S_IDLE;
            end else begin
              bit_r   <= bit_r + 1'b1;
              state_r <= S_STEP;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared modular multiplier
  rsa_mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req_r),
    .rsp   (mm_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

endmodule
